/* rtl/npf_pkg.sv */
// Shared types and constants for the near point filter.
`default_nettype none

package npf_pkg;

  localparam int COORD_W         = 14;
  localparam int COORD_FRAC_BITS = 4;
  localparam int SQ_W            = 2 * COORD_W + 1;

  // 3.0 pixels in Q10.4
  localparam logic [COORD_W-1:0] NEAR_THRESHOLD_RESET = COORD_W'(3 << COORD_FRAC_BITS);

  typedef struct packed {
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] kept_x;
    logic [COORD_W-1:0] kept_y;
    logic               kept_last;
  } out_item_t;

  typedef enum logic [1:0] {
    SQ_NOP  = 2'd0,
    SQ_LOAD = 2'd1,
    SQ_ACC  = 2'd2
  } sq_op_t;

  typedef struct packed {
    sq_op_t             op;
    logic [COORD_W-1:0] operand;
  } sq_ctl_t;

endpackage

`default_nettype wire

/* rtl/npf_sq_unit.sv */
// Shared square / square-accumulate unit.
`default_nettype none

module npf_sq_unit (
  input  logic                     clk,
  input  npf_pkg::sq_ctl_t         ctl,
  output logic [npf_pkg::SQ_W-1:0] acc
);
  import npf_pkg::*;

  logic [2*COORD_W-1:0] square;

  assign square = ctl.operand * ctl.operand;

  always_ff @(posedge clk) begin
    case (ctl.op)
      SQ_LOAD: acc <= SQ_W'(square);
      SQ_ACC:  acc <= acc + SQ_W'(square);
      default: acc <= acc;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/near_point_filter.sv */
// Top level of the near point filter: point store, sequencer and output register.
//
//  channel | signals                          | direction | word
//  --------+----------------------------------+-----------+-----------------------------
//  in      | in_valid, in_ready, in_item      | in        | one point, last_point ends list
//  out     | out_valid, out_ready, out_item   | out       | one surviving point
//  cfg     | cfg_valid, cfg_ready, cfg_data   | in        | near_threshold
//
// Loading takes one point per cycle. The last point drops in_ready and starts the filter:
// the threshold is squared, then each outer point is read and checked against each inner
// point, which is skipped or measured on the shared square unit. Emission walks down to
// the final survivor, then up the list, loading each survivor and skipping removed points;
// out_ready low stalls the walk. Intake resumes once the final word is loaded. Reset (rst,
// synchronous) empties the list and sets near_threshold to 3.0 pixels.
`default_nettype none

module near_point_filter #(
  parameter int MAX_POINTS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  npf_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output npf_pkg::out_item_t            out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [npf_pkg::COORD_W-1:0]   cfg_data
);
  import npf_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [12:0] {
    S_LOAD  = 13'b0000000000001,
    S_TSQ   = 13'b0000000000010,
    S_TSQ2  = 13'b0000000000100,
    S_RDI   = 13'b0000000001000,
    S_GETI  = 13'b0000000010000,
    S_RDJ   = 13'b0000000100000,
    S_DX    = 13'b0000001000000,
    S_MX    = 13'b0000010000000,
    S_MY    = 13'b0000100000000,
    S_CMP   = 13'b0001000000000,
    S_FINDL = 13'b0010000000000,
    S_ESKIP = 13'b0100000000000,
    S_ELD   = 13'b1000000000000
  } state_t;

  state_t state;

  // point store: x in the upper half, y in the lower
  logic [2*COORD_W-1:0] mem [MAX_POINTS];
  logic [2*COORD_W-1:0] rdata;
  logic [AW-1:0]        rd_addr;
  logic [COORD_W-1:0]   rd_x, rd_y;

  logic [COORD_W-1:0]    near_threshold;
  logic [CW-1:0]         count;
  logic [CW-1:0]         nm1;
  logic [MAX_POINTS-1:0] removed;
  logic [AW-1:0]         i, j, k, last_idx;
  logic [COORD_W-1:0]    xi, yi, dx, dy;
  logic [SQ_W-2:0]       tsq;
  logic [SQ_W-1:0]       acc;
  sq_ctl_t               sq_ctl;

  logic in_acc, out_acc, out_free;
  logic i_last, j_last, near, do_store;

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  assign in_ready  = (state == S_LOAD);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid & in_ready;
  assign out_acc   = out_valid & out_ready;
  assign out_free  = ~out_valid | out_ready;
  assign do_store  = in_acc && (count < CW'(MAX_POINTS));

  assign nm1    = count - 1'b1;
  assign i_last = (CW'(i) == nm1);
  assign j_last = (CW'(j) == nm1);
  assign rd_x   = rdata[2*COORD_W-1:COORD_W];
  assign rd_y   = rdata[COORD_W-1:0];
  // exact duplicates count even at zero threshold
  assign near   = (acc == '0) || (acc < {1'b0, tsq});

  // memory read address
  always_comb begin
    case (state)
      S_RDJ:   rd_addr = j;
      S_ESKIP: rd_addr = k;
      default: rd_addr = i;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_store) begin
      mem[count[AW-1:0]] <= {in_item.point_x, in_item.point_y};
    end
    rdata <= mem[rd_addr];
  end

  // shared square unit control
  always_comb begin
    sq_ctl.op      = SQ_NOP;
    sq_ctl.operand = dx;
    case (state)
      S_TSQ: begin
        sq_ctl.op      = SQ_LOAD;
        sq_ctl.operand = near_threshold;
      end
      S_MX: begin
        sq_ctl.op      = SQ_LOAD;
        sq_ctl.operand = dx;
      end
      S_MY: begin
        sq_ctl.op      = SQ_ACC;
        sq_ctl.operand = dy;
      end
      default: sq_ctl.op = SQ_NOP;
    endcase
  end

  npf_sq_unit u_sq (
    .clk (clk),
    .ctl (sq_ctl),
    .acc (acc)
  );

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      near_threshold <= NEAR_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      near_threshold <= cfg_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_ELD) begin
      out_valid <= 1'b1;
    end else if (out_acc) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ELD) begin
      out_item.kept_x    <= rd_x;
      out_item.kept_y    <= rd_y;
      out_item.kept_last <= (k == last_idx);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      count   <= '0;
      removed <= '0;
      i       <= '0;
      j       <= '0;
      k       <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (do_store) begin
            count <= count + 1'b1;
          end
          if (in_acc && in_item.last_point) begin
            state <= S_TSQ;
          end
        end
        S_TSQ: state <= S_TSQ2;
        S_TSQ2: begin
          tsq   <= acc[SQ_W-2:0];
          i     <= '0;
          state <= S_RDI;
        end
        S_RDI: state <= S_GETI;
        S_GETI: begin
          xi <= rd_x;
          yi <= rd_y;
          if (rd_x == '0 && rd_y == '0) begin
            // origin marks an invisible LED: always kept
            if (i_last) begin
              k     <= nm1[AW-1:0];
              state <= S_FINDL;
            end else begin
              i     <= i + 1'b1;
              state <= S_RDI;
            end
          end else begin
            j     <= '0;
            state <= S_RDJ;
          end
        end
        S_RDJ: begin
          if (j == i || removed[j]) begin
            if (!j_last) begin
              j <= j + 1'b1;
            end else if (i_last) begin
              k     <= nm1[AW-1:0];
              state <= S_FINDL;
            end else begin
              i     <= i + 1'b1;
              state <= S_RDI;
            end
          end else begin
            state <= S_DX;
          end
        end
        S_DX: begin
          dx    <= abs_diff(xi, rd_x);
          dy    <= abs_diff(yi, rd_y);
          state <= S_MX;
        end
        S_MX: state <= S_MY;
        S_MY: state <= S_CMP;
        S_CMP: begin
          if (near) begin
            removed[i] <= 1'b1;
          end
          if (!near && !j_last) begin
            j     <= j + 1'b1;
            state <= S_RDJ;
          end else if (i_last) begin
            k     <= nm1[AW-1:0];
            state <= S_FINDL;
          end else begin
            i     <= i + 1'b1;
            state <= S_RDI;
          end
        end
        S_FINDL: begin
          // walk down to the final survivor; one always exists
          if (!removed[k]) begin
            last_idx <= k;
            k        <= '0;
            state    <= S_ESKIP;
          end else begin
            k <= k - 1'b1;
          end
        end
        S_ESKIP: begin
          if (removed[k]) begin
            k <= k + 1'b1;
          end else if (out_free) begin
            state <= S_ELD;
          end
        end
        S_ELD: begin
          if (k == last_idx) begin
            count   <= '0;
            removed <= '0;
            state   <= S_LOAD;
          end else begin
            k     <= k + 1'b1;
            state <= S_ESKIP;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // output register is free whenever a new word is loaded
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_ELD) |-> !out_valid)
    else $error("output word overwritten");

  // end of list stops intake
  a_last_stops: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_item.last_point) |=> !in_ready)
    else $error("intake continued after last point");

  // store never overfills
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("point count beyond store depth");

  // final survivor returns the block to an empty list
  a_list_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_ELD && k == last_idx) |=> (in_ready && count == '0 && removed == '0))
    else $error("list not cleared after final survivor");

endmodule

`default_nettype wire

/* test/npf_survivor_pkg.sv */
// Scoreboard class for the near point filter bench: list store, filter prediction, word checks.
`timescale 1ns / 100ps

package npf_survivor_pkg;
  import npf_pkg::*;

  localparam int STORE_DEPTH  = 64;
  localparam int REPORT_LIMIT = 10;

  class survivor_board;
    logic [COORD_W-1:0] held_x [STORE_DEPTH];
    logic [COORD_W-1:0] held_y [STORE_DEPTH];
    int unsigned        held_count = 0;
    logic [COORD_W-1:0] threshold = NEAR_THRESHOLD_RESET;
    out_item_t          awaited [$];
    int unsigned        lists_seen = 0;
    int unsigned        points_seen = 0;
    int unsigned        points_lost = 0;
    int unsigned        points_dropped = 0;
    int unsigned        words_checked = 0;
    int unsigned        failures = 0;

    function void fail_note(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
    endfunction

    // Store one accepted point; on the list end run the filter and queue the survivors.
    function void note_point(in_item_t p);
      bit [STORE_DEPTH-1:0] gone;
      longint               dx, dy, lim;
      int                   i, j, last_keep;
      out_item_t            w;
      points_seen++;
      if (held_count < STORE_DEPTH) begin
        held_x[held_count] = p.point_x;
        held_y[held_count] = p.point_y;
        held_count++;
      end else begin
        points_lost++;
      end
      if (!p.last_point) return;
      gone = '0;
      lim  = longint'(threshold) * longint'(threshold);
      for (i = 0; i < held_count; i++) begin
        // origin is an invisible LED, always kept
        if (held_x[i] == '0 && held_y[i] == '0) continue;
        for (j = 0; j < held_count; j++) begin
          if (j == i || gone[j]) continue;
          dx = longint'(held_x[i]) - longint'(held_x[j]);
          dy = longint'(held_y[i]) - longint'(held_y[j]);
          if ((held_x[i] == held_x[j] && held_y[i] == held_y[j]) || dx * dx + dy * dy < lim) begin
            gone[i] = 1'b1;
            break;
          end
        end
      end
      last_keep = -1;
      for (i = 0; i < held_count; i++)
        if (!gone[i]) last_keep = i;
      for (i = 0; i < held_count; i++) begin
        if (gone[i]) begin
          points_dropped++;
        end else begin
          w.kept_x    = held_x[i];
          w.kept_y    = held_y[i];
          w.kept_last = (i == last_keep);
          awaited = {awaited, w};
        end
      end
      lists_seen++;
      held_count = 0;
    endfunction

    function void check_word(out_item_t got);
      out_item_t want;
      words_checked++;
      if (awaited.size() == 0) begin
        fail_note($sformatf("unexpected word x=%0d y=%0d last=%0b",
                            got.kept_x, got.kept_y, got.kept_last));
        return;
      end
      want = awaited.pop_front();
      if (got.kept_x !== want.kept_x || got.kept_y !== want.kept_y ||
          got.kept_last !== want.kept_last)
        fail_note($sformatf("word %0d: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                            words_checked, want.kept_x, want.kept_y, want.kept_last,
                            got.kept_x, got.kept_y, got.kept_last));
    endfunction
  endclass

endpackage

/* test/testbench.sv */
// Top-level testbench for near_point_filter: stimulus, handshake drivers and end of run.
`timescale 1ns / 100ps

module testbench;
  import npf_pkg::*;
  import npf_survivor_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_CYCLES   = 300;  // long output stall, fills the block
  localparam int SETTLE_CYCLES = 20;   // quiet time after the last word of a phase
  localparam int PHASE_ITEMS   = 45;
  localparam int COORD_MAX     = (1 << COORD_W) - 1;

  typedef enum int {SHAPE_SPREAD, SHAPE_CLUSTER, SHAPE_MIXED} list_shape_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_item_t           in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [COORD_W-1:0] cfg_data = '0;

  survivor_board board;
  bit            calm = 1'b0;       // set for the last phase: no idling on either side
  bit            held_once = 1'b0;
  int unsigned   cycles = 0;
  int unsigned   settings_tried = 1;
  int            hold_left = 0;
  int            stall_left = 0;

  near_point_filter #(.MAX_POINTS(STORE_DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog: a stuck handshake or a lost word ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("near_point_filter verification failed");
      $finish;
    end
  end

  // Receiver: checks each accepted word, then picks out_ready for the next edge.
  // Once, in the middle of a list, it holds off for HOLD_CYCLES while the sender
  // keeps offering the next list, so the block backs up and drops in_ready.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        board.check_word(out_item);
        if (!held_once && board.words_checked >= 40 && !out_item.kept_last) begin
          held_once = 1'b1;
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);  // start a stall burst
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one point word and hold it until accepted. A random gap may go ahead
  // of it; valid is never dropped while a word is pending.
  task automatic offer_point(input in_item_t p);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_point(p);
  endtask

  task automatic offer_xy(input int x, input int y, input bit last);
    in_item_t p;
    p.point_x    = COORD_W'(x);
    p.point_y    = COORD_W'(y);
    p.last_point = last;
    offer_point(p);
  endtask

  // Sender pauses until every predicted survivor has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called with the block idle (after reset or after drain).
  task automatic set_threshold(input logic [COORD_W-1:0] t);
    cfg_valid <= 1'b1;
    cfg_data  <= t;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.threshold = t;
    cfg_valid <= 1'b0;
    settings_tried++;
  endtask

  // Coordinate within +-spread of c, clamped to the field range.
  function automatic logic [COORD_W-1:0] near_coord(input int c, input int spread);
    int v;
    v = c + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return COORD_W'(v);
  endfunction

  function automatic int pick_center();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return COORD_MAX;
      default: return $urandom_range(0, COORD_MAX);
    endcase
  endfunction

  // One well-formed list. Cluster points sit around a center at about the
  // threshold scale, so near hits and misses both happen; duplicates of the
  // previous point and origin points are mixed in.
  task automatic send_list(input int len, input list_shape_t shape);
    in_item_t p, prev;
    int       cx, cy, spread, k, pick;
    cx     = pick_center();
    cy     = pick_center();
    spread = int'(board.threshold) + 2;
    prev   = '0;
    for (k = 0; k < len; k++) begin
      pick = $urandom_range(0, 11);
      if (shape == SHAPE_SPREAD || (shape == SHAPE_MIXED && pick < 4)) begin
        p.point_x = COORD_W'($urandom_range(0, COORD_MAX));
        p.point_y = COORD_W'($urandom_range(0, COORD_MAX));
      end else if (pick == 11) begin
        p.point_x = '0;
        p.point_y = '0;
      end else if (pick >= 9 && k > 0) begin
        p.point_x = prev.point_x;
        p.point_y = prev.point_y;
      end else begin
        p.point_x = near_coord(cx, spread);
        p.point_y = near_coord(cy, spread);
      end
      p.last_point = (k == len - 1);
      offer_point(p);
      prev = p;
    end
  endtask

  // Random lists, mostly short, now and then a longer one; ends drained.
  task automatic run_phase(input int budget);
    int          sent, len, r;
    list_shape_t shape;
    sent = 0;
    while (sent < budget) begin
      r   = $urandom_range(0, 19);
      len = (r == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      r   = $urandom_range(0, 19);
      if (r < 10)      shape = SHAPE_CLUSTER;
      else if (r < 17) shape = SHAPE_MIXED;
      else             shape = SHAPE_SPREAD;
      send_list(len, shape);
      sent += len;
    end
    drain();
  endtask

  initial begin
    board = new;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed lists under the reset threshold of 3.0 pixels.
    // lone origin
    offer_xy(0, 0, 1'b1);
    // field extremes, with a duplicate of the first corner at the end
    offer_xy(COORD_MAX, COORD_MAX, 1'b0);
    offer_xy(0, COORD_MAX, 1'b0);
    offer_xy(COORD_MAX, 0, 1'b0);
    offer_xy(COORD_MAX, COORD_MAX, 1'b1);
    // just inside and exactly at the threshold, repeated origin, points near origin
    offer_xy(100, 100, 1'b0);
    offer_xy(147, 100, 1'b0);
    offer_xy(300, 300, 1'b0);
    offer_xy(300, 348, 1'b0);
    offer_xy(0, 0, 1'b0);
    offer_xy(0, 0, 1'b0);
    offer_xy(20, 20, 1'b0);
    offer_xy(0, 30, 1'b1);
    // tight chain of neighbors
    offer_xy(5000, 5000, 1'b0);
    offer_xy(5001, 5000, 1'b0);
    offer_xy(5000, 5001, 1'b1);
    drain();

    // zero threshold: only exact duplicates go
    set_threshold('0);
    run_phase(PHASE_ITEMS);
    // widest threshold: nearly everything collapses
    set_threshold(COORD_W'(COORD_MAX));
    run_phase(PHASE_ITEMS);
    set_threshold(COORD_W'(1));
    run_phase(PHASE_ITEMS);
    // back to 3.0 pixels: full store and lists running past it
    set_threshold(NEAR_THRESHOLD_RESET);
    send_list(STORE_DEPTH, SHAPE_CLUSTER);
    send_list(STORE_DEPTH + 6, SHAPE_MIXED);
    send_list(STORE_DEPTH, SHAPE_SPREAD);
    run_phase(PHASE_ITEMS);
    set_threshold(COORD_W'($urandom_range(2, COORD_MAX - 1)));
    run_phase(PHASE_ITEMS);
    // last stretch at full rate, no idling anywhere
    calm = 1'b1;
    set_threshold(COORD_W'($urandom_range(2, 300)));
    run_phase(PHASE_ITEMS);

    $display("Covered %0d point lists, %0d points (%0d past a full store), %0d threshold settings",
             board.lists_seen, board.points_seen, board.points_lost, settings_tried);
    $display("Checked %0d surviving words, %0d points filtered out as near duplicates",
             board.words_checked, board.points_dropped);
    if (board.failures == 0 && board.awaited.size() == 0) begin
      $display("near_point_filter verification clean");
    end else begin
      $display("near_point_filter verification failed");
    end
    $finish;
  end

endmodule
